@@ src/slxd_pkg.sv @@
// Package for the sync/length/XOR packet deframer.
// Holds field widths, register reset values, register indexes and the
// command and status structs between the controller and the datapath.
package slxd_pkg;

  localparam int ByteW   = 8;
  localparam int LenW    = 7;
  localparam int IdxW    = 6;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 8;

  localparam logic [ByteW-1:0] SyncReset   = 8'hCC;
  localparam logic [LenW-1:0]  MaxLenReset = 7'd64;

  localparam logic [CfgIdxW-1:0] CfgSyncByte  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxLength = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_cmd;     // take the command byte, seed the checksum
    logic cap_len;     // take the length byte
    logic store;       // write a payload byte into the buffer
    logic rd_en;       // issue a buffer read
    logic rd_first;    // that read is for entry zero
    logic load_empty;  // load the single result of an empty frame
    logic load_pay;    // load a payload result from the buffer
  } slxd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sync_hit;    // incoming byte equals the sync byte
    logic len_bad;     // incoming length exceeds the limit
    logic len_zero;    // incoming length is zero
    logic fill_done;   // incoming payload byte completes the frame
    logic chk_ok;      // incoming byte matches the running checksum
    logic frame_empty; // stored frame length is zero
    logic rd_last;     // buffer entry being loaded is the final one
    logic out_free;    // output register can take a result this cycle
  } slxd_status_t;

endpackage

@@ src/slxd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module slxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/slxd_dp.sv @@
// Datapath of the deframer: configuration registers, frame registers,
// running checksum, payload buffer and output register.
// Depends on slxd_pkg and slxd_ram.
module slxd_dp
  import slxd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  slxd_cmd_t          cmd_i,
  output slxd_status_t       status_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [ByteW-1:0]   command_o,
  output logic [LenW-1:0]    length_o,
  output logic               has_payload_o,
  output logic [ByteW-1:0]   data_byte_o,
  output logic [IdxW-1:0]    byte_index_o,
  output logic               last_o
);

  localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [LenW-1:0] MaxPay = LenW'(MAX_PAYLOAD);

  logic [ByteW-1:0] sync_q, sync_d;
  logic [LenW-1:0]  maxlen_q, maxlen_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  fill_q, fill_d;
  logic [ByteW-1:0] chk_q, chk_d;
  logic [LenW-1:0]  rd_idx_q, rd_idx_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_cmd_q, out_cmd_d;
  logic [LenW-1:0]  out_len_q, out_len_d;
  logic             out_has_q, out_has_d;
  logic [ByteW-1:0] out_data_q, out_data_d;
  logic [IdxW-1:0]  out_idx_q, out_idx_d;
  logic             out_last_q, out_last_d;

  logic [LenW-1:0]  limit;
  logic [LenW-1:0]  fill_next;
  logic [LenW-1:0]  rd_next;
  logic [ByteW-1:0] ram_rdata;

  always_comb begin
    limit     = (maxlen_q < MaxPay) ? maxlen_q : MaxPay;
    fill_next = fill_q + LenW'(1);
    rd_next   = cmd_i.rd_first ? '0 : rd_idx_q + LenW'(1);
  end

  always_comb begin
    status_o.sync_hit    = (rx_byte_i == sync_q);
    status_o.len_bad     = (rx_byte_i > {1'b0, limit});
    status_o.len_zero    = (rx_byte_i == '0);
    status_o.fill_done   = (fill_next >= len_q);
    status_o.chk_ok      = (rx_byte_i == chk_q);
    status_o.frame_empty = (len_q == '0);
    status_o.rd_last     = ((rd_idx_q + LenW'(1)) == len_q);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Configuration and frame bookkeeping.
  always_comb begin
    sync_d   = sync_q;
    maxlen_d = maxlen_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSyncByte:  sync_d   = cfg_wdata_i;
        CfgMaxLength: maxlen_d = cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end

    cmd_d    = cmd_q;
    len_d    = len_q;
    fill_d   = fill_q;
    chk_d    = chk_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.cap_cmd) begin
      cmd_d = rx_byte_i;
      chk_d = rx_byte_i;
    end
    if (cmd_i.cap_len) begin
      chk_d  = chk_q ^ rx_byte_i;
      fill_d = '0;
      if (!status_o.len_bad) begin
        len_d = rx_byte_i[LenW-1:0];
      end
    end
    if (cmd_i.store) begin
      chk_d  = chk_q ^ rx_byte_i;
      fill_d = fill_next;
    end
    if (cmd_i.rd_en) begin
      rd_idx_d = rd_next;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_cmd_d   = out_cmd_q;
    out_len_d   = out_len_q;
    out_has_d   = out_has_q;
    out_data_d  = out_data_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    if (cmd_i.load_empty) begin
      out_valid_d = 1'b1;
      out_cmd_d   = cmd_q;
      out_len_d   = len_q;
      out_has_d   = 1'b0;
      out_data_d  = '0;
      out_idx_d   = '0;
      out_last_d  = 1'b1;
    end else if (cmd_i.load_pay) begin
      out_valid_d = 1'b1;
      out_cmd_d   = cmd_q;
      out_len_d   = len_q;
      out_has_d   = 1'b1;
      out_data_d  = ram_rdata;
      out_idx_d   = rd_idx_q[IdxW-1:0];
      out_last_d  = status_o.rd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= SyncReset;
      maxlen_q    <= MaxLenReset;
      cmd_q       <= '0;
      len_q       <= '0;
      fill_q      <= '0;
      chk_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sync_q      <= sync_d;
      maxlen_q    <= maxlen_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      chk_q       <= chk_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cmd_q  <= out_cmd_d;
    out_len_q  <= out_len_d;
    out_has_q  <= out_has_d;
    out_data_q <= out_data_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  slxd_ram #(
    .WIDTH(ByteW),
    .DEPTH(MAX_PAYLOAD)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(fill_q[AddrW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_next[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign command_o     = out_cmd_q;
  assign length_o      = out_len_q;
  assign has_payload_o = out_has_q;
  assign data_byte_o   = out_data_q;
  assign byte_index_o  = out_idx_q;
  assign last_o        = out_last_q;

endmodule

@@ src/slxd_ctrl.sv @@
// Controller of the deframer: frame state machine that sequences capture,
// checksum test and payload readout. Depends on slxd_pkg.
module slxd_ctrl
  import slxd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  slxd_status_t status_i,
  output slxd_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StHunt,
    StCmd,
    StLen,
    StData,
    StCheck,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    case (state_q)
      StHunt: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (accept && status_i.sync_hit) begin
          state_d = StCmd;
        end
      end
      StCmd: begin
        in_ready_o    = 1'b1;
        accept        = in_valid_i;
        cmd_o.cap_cmd = accept;
        if (accept) begin
          state_d = StLen;
        end
      end
      StLen: begin
        in_ready_o    = 1'b1;
        accept        = in_valid_i;
        cmd_o.cap_len = accept;
        if (accept) begin
          if (status_i.len_bad) begin
            state_d = StHunt;
          end else if (status_i.len_zero) begin
            state_d = StCheck;
          end else begin
            state_d = StData;
          end
        end
      end
      StData: begin
        in_ready_o  = 1'b1;
        accept      = in_valid_i;
        cmd_o.store = accept;
        if (accept && status_i.fill_done) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        // An empty frame loads its result here, so wait for a free slot.
        in_ready_o = status_i.out_free;
        accept     = in_valid_i && status_i.out_free;
        if (accept) begin
          state_d = StHunt;
          if (status_i.chk_ok) begin
            if (status_i.frame_empty) begin
              cmd_o.load_empty = 1'b1;
            end else begin
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_first = 1'b1;
              state_d        = StEmit;
            end
          end
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.load_pay = 1'b1;
          if (status_i.rd_last) begin
            state_d = StHunt;
          end else begin
            cmd_o.rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_d = StHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/sync_len_xor_packet_deframer_unit.sv @@
// Top level of the sync/length/XOR-checksum packet deframer.
// Depends on slxd_pkg, slxd_ctrl, slxd_dp and slxd_ram.
//
// Usage: received link bytes enter one per beat on the s_axis channel.
// The block hunts for the sync byte, then takes a command byte, a length
// byte, that many payload bytes and a checksum byte. The checksum must
// equal the XOR of command, length and payload; otherwise the frame is
// dropped silently. A length above min(max_length, MAX_PAYLOAD) drops the
// frame at once and the block hunts again. A sync value inside a frame is
// plain data.
// A valid frame leaves on m_axis as one beat per payload byte, tlast on
// the final one, or as a single beat with tuser low for an empty frame.
// Throughput: one input byte per cycle while a frame is received, but the
// checksum byte waits for a free output register. After an accepted
// checksum the input stalls while the payload is read out of the buffer
// RAM, one beat per cycle while m_axis_tready allows; the first registered
// RAM read is issued when the checksum byte is taken.
// Configuration (sync byte, maximum length) is written through cfg_*
// while no frame is in flight. Reset clears the state machine, the
// output valid flag and the registers to sync 0xCC and maximum length 64;
// the payload buffer needs no clearing. When m_axis_tready is low the
// output register holds its beat and readout waits.
module sync_len_xor_packet_deframer_unit
  import slxd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // Byte input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  // Frame output stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [7:0] command, [14:8] length, [22:15] data_byte, [28:23] byte_index,
  // [31:29] zero
  output logic [31:0]        m_axis_tdata,
  output logic               m_axis_tuser,   // [0] has_payload
  output logic               m_axis_tlast    // last
);

  slxd_cmd_t        cmd;
  slxd_status_t     status;
  logic [ByteW-1:0] command;
  logic [LenW-1:0]  length;
  logic [ByteW-1:0] data_byte;
  logic [IdxW-1:0]  byte_index;

  slxd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  slxd_dp #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_byte_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .command_o    (command),
    .length_o     (length),
    .has_payload_o(m_axis_tuser),
    .data_byte_o  (data_byte),
    .byte_index_o (byte_index),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, byte_index, data_byte, length, command};

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the sync/length/XOR-checksum packet deframer.
// It drives received bytes on s_axis, predicts every m_axis beat with its own deframer
// model, and depends only on slxd_pkg and sync_len_xor_packet_deframer_unit.
module tb;
  import slxd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PayloadCap = 64;

  // Receive phases of the local deframer model.
  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_CMD     = 3'd1,
    ST_LEN     = 3'd2,
    ST_PAYLOAD = 3'd3,
    ST_CHECK   = 3'd4
  } rx_phase_e;

  // One output beat as the block should present it.
  typedef struct packed {
    logic [7:0] command;
    logic [6:0] length;
    logic       has_payload;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last;
  } frame_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  sync_len_xor_packet_deframer_unit #(
    .MAX_PAYLOAD(PayloadCap)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    // [7:0] command, [14:8] length, [22:15] data_byte, [28:23] byte_index
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),   // [0] has_payload
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Register copies kept in step with every configuration write.
  logic [7:0] cfg_sync = SyncReset;
  logic [6:0] cfg_max_len = MaxLenReset;

  // Deframer model state.
  rx_phase_e  rx_phase = ST_HUNT;
  logic [7:0] frame_cmd = '0;
  logic [6:0] frame_len = '0;
  logic [6:0] fill_pos = '0;
  logic [7:0] running_xor = '0;
  logic [7:0] payload_buf [PayloadCap];

  logic [7:0]  rx_bytes_pending [$];
  frame_beat_t beats_due [$];

  int mismatches = 0;
  int bytes_sent = 0;
  int bytes_queued = 0;
  int beats_checked = 0;
  int frames_seen = 0;
  int frames_dropped = 0;

  // Sender and receiver pacing.
  int tx_gap_left = 0;
  int tx_calm_left = 0;
  int rx_stall_left = 0;
  int rx_calm_left = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_taken = 1'b0;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Advances the model by one received byte and queues the beats a valid
  // checksum releases. The effective length limit is the smaller of the
  // max_length register and the buffer size.
  function automatic void deframe_byte(input logic [7:0] rx);
    int          lim;
    frame_beat_t beat;
    lim = (cfg_max_len < PayloadCap) ? int'(cfg_max_len) : PayloadCap;
    case (rx_phase)
      ST_CMD: begin
        frame_cmd   = rx;
        running_xor = rx;
        rx_phase    = ST_LEN;
      end
      ST_LEN: begin
        running_xor ^= rx;
        fill_pos = '0;
        if (int'(rx) > lim) begin
          // Oversized length: the frame is abandoned right here.
          rx_phase = ST_HUNT;
          frames_dropped++;
        end else begin
          frame_len = rx[6:0];
          rx_phase  = (rx == 8'd0) ? ST_CHECK : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        // A sync value in the payload is ordinary data.
        if (fill_pos < PayloadCap) payload_buf[fill_pos[5:0]] = rx;
        fill_pos = fill_pos + 7'd1;
        running_xor ^= rx;
        if (fill_pos >= frame_len) rx_phase = ST_CHECK;
      end
      ST_CHECK: begin
        if (rx == running_xor) begin
          beat.command = frame_cmd;
          beat.length  = frame_len;
          if (frame_len == 7'd0) begin
            // An empty frame still yields one beat, without payload.
            beat.has_payload = 1'b0;
            beat.data_byte   = '0;
            beat.byte_index  = '0;
            beat.last        = 1'b1;
            beats_due.push_back(beat);
          end else begin
            for (int i = 0; i < int'(frame_len); i++) begin
              beat.has_payload = 1'b1;
              beat.data_byte   = payload_buf[i];
              beat.byte_index  = i[5:0];
              beat.last        = (i + 1 == int'(frame_len));
              beats_due.push_back(beat);
            end
          end
        end else begin
          frames_dropped++;
        end
        rx_phase = ST_HUNT;
      end
      default: begin
        rx_phase = (rx == cfg_sync) ? ST_CMD : ST_HUNT;
      end
    endcase
  endfunction

  // Gap after an accepted byte: mostly none, a few short ones, rarely long,
  // and now and then a calm stretch with back-to-back bytes.
  function automatic int pick_tx_gap();
    int r;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) tx_calm_left = $urandom_range(20, 60);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_rx_stall();
    int r;
    if (rx_calm_left > 0) begin
      rx_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) rx_calm_left = $urandom_range(20, 60);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Byte driver. The byte on offer is the head of the pending queue and
  // leaves it only when the beat is taken; prediction happens at that edge.
  always @(posedge clk_i) begin
    logic offering;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offering = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        void'(rx_bytes_pending.pop_front());
        bytes_sent++;
        tx_gap_left = pick_tx_gap();
        offering = 1'b0;
      end
      if (!offering) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_pending.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_bytes_pending[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: every accepted beat is checked against the prediction.
  always @(posedge clk_i) begin
    frame_beat_t got;
    frame_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.command     = m_axis_tdata[7:0];
      got.length      = m_axis_tdata[14:8];
      got.data_byte   = m_axis_tdata[22:15];
      got.byte_index  = m_axis_tdata[28:23];
      got.has_payload = m_axis_tuser;
      got.last        = m_axis_tlast;
      if (beats_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", got));
      end else begin
        want = beats_due.pop_front();
        beats_checked++;
        if (want.last) frames_seen++;
        if (got.command !== want.command)
          report_mismatch($sformatf("command %h, want %h", got.command, want.command));
        if (got.length !== want.length)
          report_mismatch($sformatf("length %0d, want %0d", got.length, want.length));
        if (got.has_payload !== want.has_payload)
          report_mismatch($sformatf("has_payload %b, want %b",
                                    got.has_payload, want.has_payload));
        if (got.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %h, want %h at index %0d",
                                    got.data_byte, want.data_byte, want.byte_index));
        if (got.byte_index !== want.byte_index)
          report_mismatch($sformatf("byte_index %0d, want %0d",
                                    got.byte_index, want.byte_index));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      end
    end
  end

  // Receiver pacing. A one-time long hold lets the block back up until its
  // input stalls while the driver keeps offering bytes.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        rx_stall_left = 300;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_stall_left = pick_rx_stall();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  // Queues a whole frame with random payload; now and then a payload byte
  // equals the sync value. A corrupt frame gets a wrong checksum.
  task automatic queue_frame(input logic [7:0] cmd, input int len, input bit corrupt);
    logic [7:0] chk;
    logic [7:0] b;
    send_byte(cfg_sync);
    send_byte(cmd);
    send_byte(len[7:0]);
    chk = cmd ^ len[7:0];
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 15) == 0) ? cfg_sync : 8'($urandom_range(0, 255));
      send_byte(b);
      chk ^= b;
    end
    if (corrupt) chk ^= 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  // Mostly well-formed frames of small length, with bad checksums,
  // oversized lengths, cut-off headers and loose noise mixed in.
  task automatic queue_traffic(input int n_bytes, input int big_frames);
    int stop_at;
    int lim;
    int small_max;
    int r;
    int big_left;
    big_left = big_frames;
    stop_at = bytes_queued + n_bytes;
    lim = (cfg_max_len < PayloadCap) ? int'(cfg_max_len) : PayloadCap;
    small_max = (lim < 6) ? lim : 6;
    while (bytes_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 58) begin
        queue_frame(8'($urandom_range(0, 255)), $urandom_range(0, small_max), 1'b0);
      end else if (r < 64) begin
        if (big_left > 0) begin
          big_left--;
          queue_frame(8'($urandom_range(0, 255)), lim, 1'b0);
        end else begin
          queue_frame(8'($urandom_range(0, 255)), small_max, 1'b0);
        end
      end else if (r < 76) begin
        queue_frame(8'($urandom_range(0, 255)), $urandom_range(0, small_max), 1'b1);
      end else if (r < 85) begin
        send_byte(cfg_sync);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(lim + 1, 255)));
      end else if (r < 91) begin
        // Header cut short: the following bytes fall into this frame.
        send_byte(cfg_sync);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Holds the sender back until every queued byte is taken and every
  // predicted beat has been seen, then lets the block settle.
  task automatic wait_quiet(input int extra);
    while (rx_bytes_pending.size() != 0 || s_axis_tvalid || beats_due.size() != 0)
      @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Brings the block back to hunting before a register write, feeding
  // filler bytes that cannot start a frame.
  task automatic settle_to_hunt();
    wait_quiet(8);
    while (rx_phase != ST_HUNT) begin
      send_byte(cfg_sync ^ 8'hFF);
      wait_quiet(8);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgSyncByte:  cfg_sync = value;
      CfgMaxLength: cfg_max_len = value[6:0];
      default: ;
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bytes under the reset settings (sync 0xCC, limit 64).
    // Empty frame with all-zero command and checksum.
    send_byte(8'hCC); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    // One-byte frame with all-ones command and data.
    send_byte(8'hCC); send_byte(8'hFF); send_byte(8'h01); send_byte(8'hFF);
    send_byte(8'h01);
    // Empty frame with a wrong checksum is dropped without a beat.
    send_byte(8'hCC); send_byte(8'h5A); send_byte(8'h00); send_byte(8'hA5);
    // Length one above the limit abandons the frame.
    send_byte(8'hCC); send_byte(8'h11); send_byte(8'h41);
    // Sync value inside the payload is kept as data.
    send_byte(8'hCC); send_byte(8'h22); send_byte(8'h02); send_byte(8'hCC);
    send_byte(8'h00); send_byte(8'hEC);
    // Loose bytes while hunting.
    send_byte(8'h00); send_byte(8'hFF);
    // Largest payload.
    queue_frame(8'h3C, PayloadCap, 1'b0);
    wait_quiet(0);

    // Random traffic; the receiver holds off for a long time at the start
    // so the output backs up, and the sender later pauses until drained.
    queue_traffic(40, 0);
    long_hold_req = 1'b1;
    wait_quiet(0);
    queue_traffic(35, 0);

    // Both registers at their low extremes: only empty frames pass.
    settle_to_hunt();
    write_reg(CfgSyncByte, 8'h00);
    write_reg(CfgMaxLength, 8'h00);
    queue_traffic(40, 0);

    // All-ones on both registers: the limit is then set by the buffer size.
    settle_to_hunt();
    write_reg(CfgSyncByte, 8'hFF);
    write_reg(CfgMaxLength, 8'hFF);
    queue_frame(8'hA5, PayloadCap, 1'b0);
    send_byte(8'hFF); send_byte(8'h01); send_byte(8'(PayloadCap + 1));
    queue_traffic(30, 0);

    // A random sync value with a short limit.
    settle_to_hunt();
    write_reg(CfgSyncByte, 8'($urandom_range(0, 255)));
    write_reg(CfgMaxLength, 8'($urandom_range(1, 20)));
    queue_traffic(40, 2);

    settle_to_hunt();
    wait_quiet(20);
    $display("Sent %0d bytes across four register settings, with gaps and a long output hold.",
             bytes_sent);
    $display("Checked %0d beats in %0d frames; %0d frames were dropped by length or checksum.",
             beats_checked, frames_seen, frames_dropped);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("TIMEOUT: %0d beats still expected", beats_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/slxd_pkg.sv
src/slxd_ram.sv
src/slxd_dp.sv
src/slxd_ctrl.sv
src/sync_len_xor_packet_deframer_unit.sv
bench/tb.sv
